[rtl/core/scancode_to_ascii_keyboard_fifo_macros.svh]
// assertion macros for the keyboard fifo checker
`ifndef SCANCODE_TO_ASCII_KEYBOARD_FIFO_MACROS_SVH
`define SCANCODE_TO_ASCII_KEYBOARD_FIFO_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SCTA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scta check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SCTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scta check failed");

`endif

[rtl/core/scta_pkg.sv]
// shared types, constants and the us layout table for the keyboard fifo
`default_nettype none

package scta_pkg;

  // storage sizes
  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int KEY_COUNT  = 128;
  localparam int KEY_AW     = $clog2(KEY_COUNT);

  // request kinds; the unused code behaves as a query
  typedef enum logic [1:0] {
    ACT_SCAN  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  // set 1 make codes of the keys with special handling
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_ALT    = 7'h38;
  localparam logic [6:0] SC_CAPS   = 7'h3A;

  // control characters in the table
  localparam logic [6:0] CH_BS  = 7'd8;
  localparam logic [6:0] CH_TAB = 7'd9;
  localparam logic [6:0] CH_LF  = 7'd10;
  localparam logic [6:0] CH_ESC = 7'd27;

  typedef struct packed {
    logic caps;
    logic alt;
    logic ctrl;
    logic rshift;
    logic lshift;
  } mod_flags_t;

  // one write into the key table
  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    logic              data;
  } key_wr_t;

  // circular pointer advance
  function automatic logic [PTR_W-1:0] fifo_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  // us layout: {lower, upper} per make code, zero where nothing is typed
  function automatic logic [6:0] scta_xlate(input logic [6:0] code, input logic upper);
    logic [13:0] pair;
    unique case (code)
      7'h01: pair = {CH_ESC, CH_ESC};
      7'h02: pair = {7'h31, 7'h21};
      7'h03: pair = {7'h32, 7'h40};
      7'h04: pair = {7'h33, 7'h23};
      7'h05: pair = {7'h34, 7'h24};
      7'h06: pair = {7'h35, 7'h25};
      7'h07: pair = {7'h36, 7'h5E};
      7'h08: pair = {7'h37, 7'h26};
      7'h09: pair = {7'h38, 7'h2A};
      7'h0A: pair = {7'h39, 7'h28};
      7'h0B: pair = {7'h30, 7'h29};
      7'h0C: pair = {7'h2D, 7'h5F};
      7'h0D: pair = {7'h3D, 7'h2B};
      7'h0E: pair = {CH_BS, CH_BS};
      7'h0F: pair = {CH_TAB, CH_TAB};
      7'h10: pair = {7'h71, 7'h51};
      7'h11: pair = {7'h77, 7'h57};
      7'h12: pair = {7'h65, 7'h45};
      7'h13: pair = {7'h72, 7'h52};
      7'h14: pair = {7'h74, 7'h54};
      7'h15: pair = {7'h79, 7'h59};
      7'h16: pair = {7'h75, 7'h55};
      7'h17: pair = {7'h69, 7'h49};
      7'h18: pair = {7'h6F, 7'h4F};
      7'h19: pair = {7'h70, 7'h50};
      7'h1A: pair = {7'h5B, 7'h7B};
      7'h1B: pair = {7'h5D, 7'h7D};
      7'h1C: pair = {CH_LF, CH_LF};
      7'h1E: pair = {7'h61, 7'h41};
      7'h1F: pair = {7'h73, 7'h53};
      7'h20: pair = {7'h64, 7'h44};
      7'h21: pair = {7'h66, 7'h46};
      7'h22: pair = {7'h67, 7'h47};
      7'h23: pair = {7'h68, 7'h48};
      7'h24: pair = {7'h6A, 7'h4A};
      7'h25: pair = {7'h6B, 7'h4B};
      7'h26: pair = {7'h6C, 7'h4C};
      7'h27: pair = {7'h3B, 7'h3A};
      7'h28: pair = {7'h27, 7'h22};
      7'h29: pair = {7'h60, 7'h7E};
      7'h2B: pair = {7'h5C, 7'h7C};
      7'h2C: pair = {7'h7A, 7'h5A};
      7'h2D: pair = {7'h78, 7'h58};
      7'h2E: pair = {7'h63, 7'h43};
      7'h2F: pair = {7'h76, 7'h56};
      7'h30: pair = {7'h62, 7'h42};
      7'h31: pair = {7'h6E, 7'h4E};
      7'h32: pair = {7'h6D, 7'h4D};
      7'h33: pair = {7'h2C, 7'h3C};
      7'h34: pair = {7'h2E, 7'h3E};
      7'h35: pair = {7'h2F, 7'h3F};
      7'h37: pair = {7'h2A, 7'h2A};
      7'h39: pair = {7'h20, 7'h20};
      7'h4A: pair = {7'h2D, 7'h2D};
      7'h4E: pair = {7'h2B, 7'h2B};
      default: pair = '0;
    endcase
    return upper ? pair[6:0] : pair[13:7];
  endfunction

endpackage

`default_nettype wire

[rtl/core/scta_ram.sv]
// simple dual port ram, one write and one registered read per cycle
`default_nettype none

module scta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/scta_keymap.sv]
// pressed-key table in ram with a clearing sweep after reset
`default_nettype none

module scta_keymap (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire scta_pkg::key_wr_t       wr,
  input  wire logic                    re,
  input  wire logic [scta_pkg::KEY_AW-1:0] raddr,
  output logic                         rdata,
  output logic                         busy
);
  import scta_pkg::*;

  logic              busy_r, busy_nxt;
  logic [KEY_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic              ram_we;
  logic [KEY_AW-1:0] ram_waddr;
  logic              ram_wdata;

  // sweep one entry per cycle until the last one is cleared
  always_comb begin
    busy_nxt    = busy_r && (clr_idx_r != KEY_AW'(KEY_COUNT - 1));
    clr_idx_nxt = busy_r ? clr_idx_r + 1'b1 : clr_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // sweep owns the write port while it runs
  always_comb begin
    ram_we    = busy_r || wr.en;
    ram_waddr = busy_r ? clr_idx_r : wr.addr;
    ram_wdata = busy_r ? 1'b0 : wr.data;
  end

  scta_ram #(
    .WIDTH(1),
    .DEPTH(KEY_COUNT)
  ) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy = busy_r;

endmodule

`default_nettype wire

[rtl/core/scancode_to_ascii_keyboard_fifo.sv]
// set 1 scan code to ascii translator with a character fifo, top level
// a request's result is registered in the read stage, then in the output stage
// throughput: one request per cycle while not stalled; the key table and the
//   character ram each take a write at accept and give read data the next cycle
// reset: rst_n synchronous, active low; after it the key table is cleared one
//   entry a cycle, all KEY_COUNT (128) entries, while in_stall stays high
`default_nettype none

module scancode_to_ascii_keyboard_fifo (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_action,
  input  wire logic [7:0] in_scan_byte,
  input  wire logic [7:0] in_query_key,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [6:0] out_char_out,
  output logic            out_char_valid,
  output logic            out_fifo_nonempty,
  output logic            out_fifo_overflow,
  output logic            out_key_down,
  output logic            out_left_shift_held,
  output logic            out_right_shift_held,
  output logic            out_ctrl_held,
  output logic            out_alt_held,
  output logic            out_caps_on
);
  import scta_pkg::*;

  logic              acc, s1_adv, key_busy;
  logic              is_scan, is_pop, is_rel, is_mod, upper;
  logic [6:0]        code, xl_char;
  logic              push, full, push_ok, ovf, pop_ok;
  mod_flags_t        flags_r, flags_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  key_wr_t           key_wr;
  logic [KEY_AW-1:0] key_raddr;
  logic              key_rdata;
  logic [6:0]        char_rdata;

  // read stage
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_pop_r, s1_ovf_r, s1_nonempty_r, s1_qhi_r, s1_fwd_r, s1_fwd_val_r;
  mod_flags_t s1_flags_r;

  // output stage
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] out_char_r;
  logic       out_cv_r, out_ne_r, out_ovf_r, out_kd_r;
  mod_flags_t out_flags_r;

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = key_busy || (s1_valid_r && !s1_adv);
  assign acc      = in_valid && !in_stall;

  // request decode
  assign code    = in_scan_byte[6:0];
  assign is_scan = (in_action == ACT_SCAN);
  assign is_pop  = (in_action == ACT_POP);
  assign is_rel  = in_scan_byte[7];
  assign is_mod  = (code == SC_LSHIFT) || (code == SC_RSHIFT) || (code == SC_CTRL) ||
                   (code == SC_ALT) || (code == SC_CAPS);

  // translation uses the flags from before this request
  assign upper   = (flags_r.lshift || flags_r.rshift) ^ flags_r.caps;
  assign xl_char = scta_xlate(code, upper);

  // fifo push and pop
  assign full    = (fifo_inc(head_r) == tail_r);
  assign push    = acc && is_scan && !is_rel && !is_mod && (xl_char != '0);
  assign push_ok = push && !full;
  assign ovf     = push && full;
  assign pop_ok  = acc && is_pop && (head_r != tail_r);

  always_comb begin
    head_nxt = push_ok ? fifo_inc(head_r) : head_r;
    tail_nxt = pop_ok ? fifo_inc(tail_r) : tail_r;
  end

  // modifier flag update
  always_comb begin
    flags_nxt = flags_r;
    if (acc && is_scan) begin
      if (is_rel) begin
        unique case (code)
          SC_LSHIFT: flags_nxt.lshift = 1'b0;
          SC_RSHIFT: flags_nxt.rshift = 1'b0;
          SC_CTRL:   flags_nxt.ctrl   = 1'b0;
          SC_ALT:    flags_nxt.alt    = 1'b0;
          default: ;
        endcase
      end else begin
        unique case (code)
          SC_LSHIFT: flags_nxt.lshift = 1'b1;
          SC_RSHIFT: flags_nxt.rshift = 1'b1;
          SC_CTRL:   flags_nxt.ctrl   = 1'b1;
          SC_ALT:    flags_nxt.alt    = 1'b1;
          SC_CAPS:   flags_nxt.caps   = !flags_r.caps;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      flags_r <= flags_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  // key table: write at accept, query read lands in the next cycle
  always_comb begin
    key_wr.en   = acc && is_scan;
    key_wr.addr = KEY_AW'(code);
    key_wr.data = !is_rel;
    key_raddr   = KEY_AW'(in_query_key[6:0]);
  end

  scta_keymap u_keymap (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (key_wr),
    .re   (acc),
    .raddr(key_raddr),
    .rdata(key_rdata),
    .busy (key_busy)
  );

  // character store, never cleared
  scta_ram #(
    .WIDTH(7),
    .DEPTH(FIFO_DEPTH)
  ) u_char_ram (
    .clk  (clk),
    .we   (push_ok),
    .waddr(head_r),
    .wdata(xl_char),
    .re   (pop_ok),
    .raddr(tail_r),
    .rdata(char_rdata)
  );

  // read stage control
  always_comb begin
    s1_valid_nxt = acc || (s1_valid_r && !s1_adv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // read stage payload; forward a write to the queried key in the same request
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pop_r      <= pop_ok;
      s1_ovf_r      <= ovf;
      s1_nonempty_r <= (head_nxt != tail_nxt);
      s1_qhi_r      <= in_query_key[7];
      s1_fwd_r      <= key_wr.en && (key_wr.addr == key_raddr);
      s1_fwd_val_r  <= key_wr.data;
      s1_flags_r    <= flags_nxt;
    end
  end

  // output register control
  always_comb begin
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload, picks up the ram read data
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_char_r  <= s1_pop_r ? char_rdata : 7'd0;
      out_cv_r    <= s1_pop_r;
      out_ne_r    <= s1_nonempty_r;
      out_ovf_r   <= s1_ovf_r;
      out_kd_r    <= !s1_qhi_r && (s1_fwd_r ? s1_fwd_val_r : key_rdata);
      out_flags_r <= s1_flags_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_char_out         = out_char_r;
  assign out_char_valid       = out_cv_r;
  assign out_fifo_nonempty    = out_ne_r;
  assign out_fifo_overflow    = out_ovf_r;
  assign out_key_down         = out_kd_r;
  assign out_left_shift_held  = out_flags_r.lshift;
  assign out_right_shift_held = out_flags_r.rshift;
  assign out_ctrl_held        = out_flags_r.ctrl;
  assign out_alt_held         = out_flags_r.alt;
  assign out_caps_on          = out_flags_r.caps;

endmodule

`default_nettype wire

[rtl/core/scta_checker.sv]
// port-level checks for the keyboard fifo, bound to the top level
`default_nettype none
`include "scancode_to_ascii_keyboard_fifo_macros.svh"

module scta_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_action,
  input wire logic [7:0] in_scan_byte,
  input wire logic [7:0] in_query_key,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [6:0] out_char_out,
  input wire logic       out_char_valid,
  input wire logic       out_fifo_nonempty,
  input wire logic       out_fifo_overflow,
  input wire logic       out_key_down,
  input wire logic       out_left_shift_held,
  input wire logic       out_right_shift_held,
  input wire logic       out_ctrl_held,
  input wire logic       out_alt_held,
  input wire logic       out_caps_on
);

  logic [17:0] in_word;
  logic [15:0] out_word;

  // whole request and whole result as single words
  assign in_word  = {in_action, in_scan_byte, in_query_key};
  assign out_word = {out_char_out, out_char_valid, out_fifo_nonempty, out_fifo_overflow,
                     out_key_down, out_left_shift_held, out_right_shift_held,
                     out_ctrl_held, out_alt_held, out_caps_on};

  // a stalled request stays put
  `SCTA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word))

  // a stalled result stays put
  `SCTA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // no popped character means a zero character
  `SCTA_ASSERT_IMPLY(a_char_zero, out_valid && !out_char_valid, out_char_out == 7'd0)

  // a pop and a dropped character never come from the same request
  `SCTA_ASSERT_IMPLY(a_pop_vs_ovf, out_valid, !(out_char_valid && out_fifo_overflow))

  // a drop only happens when the fifo is full, so it cannot be empty after
  `SCTA_ASSERT_IMPLY(a_ovf_nonempty, out_valid && out_fifo_overflow, out_fifo_nonempty)

endmodule

bind scancode_to_ascii_keyboard_fifo scta_checker u_scta_checker (.*);

`default_nettype wire

[bench/tb_scancode_to_ascii_keyboard_fifo.sv]
// testbench for the set 1 scan code to ascii translator with its character fifo
`default_nettype none

module tb_scancode_to_ascii_keyboard_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import scta_pkg::*;

  // the spare action code, handled like a query
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // one status word as the block reports it, msb first
  typedef struct packed {
    logic [6:0] ch;
    logic       valid;
    logic       nonempty;
    logic       overflow;
    logic       down;
    logic       lshift;
    logic       rshift;
    logic       ctrl;
    logic       alt;
    logic       caps;
  } kb_status_t;

  // tracks key, modifier and fifo state and the status words still due
  class keyboard_scoreboard;
    bit [6:0]   lower_tab[128];
    bit [6:0]   upper_tab[128];
    bit [127:0] keys_down;
    mod_flags_t mods;
    bit [6:0]   typed_chars[$];
    kb_status_t status_due[$];
    int errors;
    int checked;
    int chars_popped;
    int chars_dropped;

    function new();
      foreach (lower_tab[i]) begin
        lower_tab[i] = '0;
        upper_tab[i] = '0;
      end
      put_run(8'h02, "1234567890-=", "!@#$%^&*()_+");
      put_run(8'h10, "qwertyuiop[]", "QWERTYUIOP{}");
      put_run(8'h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
      put_run(8'h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
      lower_tab[8'h01] = CH_ESC; upper_tab[8'h01] = CH_ESC;
      lower_tab[8'h0E] = CH_BS;  upper_tab[8'h0E] = CH_BS;
      lower_tab[8'h0F] = CH_TAB; upper_tab[8'h0F] = CH_TAB;
      lower_tab[8'h1C] = CH_LF;  upper_tab[8'h1C] = CH_LF;
      lower_tab[8'h29] = 7'h60;  upper_tab[8'h29] = 7'h7E;
      lower_tab[8'h37] = 7'h2A;  upper_tab[8'h37] = 7'h2A;
      lower_tab[8'h39] = 7'h20;  upper_tab[8'h39] = 7'h20;
      // keypad minus and plus
      lower_tab[8'h4A] = 7'h2D;  upper_tab[8'h4A] = 7'h2D;
      lower_tab[8'h4E] = 7'h2B;  upper_tab[8'h4E] = 7'h2B;
      keys_down = '0;
      mods = '0;
      errors = 0;
      checked = 0;
      chars_popped = 0;
      chars_dropped = 0;
    endfunction

    function void put_run(int base, string lo, string up);
      for (int i = 0; i < lo.len(); i++) begin
        lower_tab[base + i] = 7'(lo[i]);
        upper_tab[base + i] = 7'(up[i]);
      end
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    // apply one accepted request and queue the status word it should give
    function void note_request(logic [1:0] act, logic [7:0] sb, logic [7:0] qk);
      kb_status_t st;
      bit [6:0] code;
      bit [6:0] c;
      st = '0;
      code = sb[6:0];
      if (act == ACT_SCAN) begin
        if (sb[7]) begin
          // release: key bit and its modifier go low, caps stays
          keys_down[code] = 1'b0;
          if (code == SC_LSHIFT) mods.lshift = 1'b0;
          else if (code == SC_RSHIFT) mods.rshift = 1'b0;
          else if (code == SC_CTRL) mods.ctrl = 1'b0;
          else if (code == SC_ALT) mods.alt = 1'b0;
        end else begin
          keys_down[code] = 1'b1;
          if (code == SC_LSHIFT) mods.lshift = 1'b1;
          else if (code == SC_RSHIFT) mods.rshift = 1'b1;
          else if (code == SC_CTRL) mods.ctrl = 1'b1;
          else if (code == SC_ALT) mods.alt = 1'b1;
          else if (code == SC_CAPS) mods.caps = ~mods.caps;
          else begin
            c = ((mods.lshift | mods.rshift) ^ mods.caps) ? upper_tab[code] : lower_tab[code];
            if (c != 7'd0) begin
              if (typed_chars.size() == FIFO_DEPTH - 1) begin
                st.overflow = 1'b1;
                chars_dropped++;
              end else begin
                typed_chars.push_back(c);
              end
            end
          end
        end
      end else if (act == ACT_POP) begin
        if (typed_chars.size() != 0) begin
          st.ch = typed_chars.pop_front();
          st.valid = 1'b1;
          chars_popped++;
        end
      end
      st.nonempty = (typed_chars.size() != 0);
      st.down = (qk < KEY_COUNT) ? keys_down[qk[6:0]] : 1'b0;
      st.lshift = mods.lshift;
      st.rshift = mods.rshift;
      st.ctrl = mods.ctrl;
      st.alt = mods.alt;
      st.caps = mods.caps;
      status_due.push_back(st);
    endfunction

    function void cmp_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted status word with the oldest one due
    function void check_status(kb_status_t got);
      kb_status_t want;
      if (status_due.size() == 0) begin
        $display("%0t: status word with none due, actual %h", $time, got);
        errors++;
        return;
      end
      want = status_due.pop_front();
      checked++;
      cmp_field("char_out", want.ch, got.ch);
      cmp_field("char_valid", want.valid, got.valid);
      cmp_field("fifo_nonempty", want.nonempty, got.nonempty);
      cmp_field("fifo_overflow", want.overflow, got.overflow);
      cmp_field("key_down", want.down, got.down);
      cmp_field("left_shift_held", want.lshift, got.lshift);
      cmp_field("right_shift_held", want.rshift, got.rshift);
      cmp_field("ctrl_held", want.ctrl, got.ctrl);
      cmp_field("alt_held", want.alt, got.alt);
      cmp_field("caps_on", want.caps, got.caps);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_action;
  logic [7:0] in_scan_byte;
  logic [7:0] in_query_key;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] out_char_out;
  logic       out_char_valid;
  logic       out_fifo_nonempty;
  logic       out_fifo_overflow;
  logic       out_key_down;
  logic       out_left_shift_held;
  logic       out_right_shift_held;
  logic       out_ctrl_held;
  logic       out_alt_held;
  logic       out_caps_on;

  keyboard_scoreboard kbd;
  bit tx_gaps;
  bit rx_gaps;
  bit long_hold;
  int requests;

  scancode_to_ascii_keyboard_fifo DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_scan_byte         (in_scan_byte),
    .in_query_key         (in_query_key),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_char_out         (out_char_out),
    .out_char_valid       (out_char_valid),
    .out_fifo_nonempty    (out_fifo_nonempty),
    .out_fifo_overflow    (out_fifo_overflow),
    .out_key_down         (out_key_down),
    .out_left_shift_held  (out_left_shift_held),
    .out_right_shift_held (out_right_shift_held),
    .out_ctrl_held        (out_ctrl_held),
    .out_alt_held         (out_alt_held),
    .out_caps_on          (out_caps_on)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("[scancode_to_ascii_keyboard_fifo] ERROR");
    $finish;
  end

  // result side: random stall bursts, a long hold on request
  initial begin
    int r;
    int len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (!rx_gaps) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        len = (r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // accepted status words go to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      kbd.check_status({out_char_out, out_char_valid, out_fifo_nonempty, out_fifo_overflow,
                        out_key_down, out_left_shift_held, out_right_shift_held,
                        out_ctrl_held, out_alt_held, out_caps_on});
    end
  end

  // offer one request, hold it until accepted, then maybe leave a gap
  task automatic send(input logic [1:0] act, input logic [7:0] sb, input logic [7:0] qk);
    int r;
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_scan_byte <= sb;
    in_query_key <= qk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    kbd.note_request(act, sb, qk);
    requests++;
    gap = 0;
    if (tx_gaps) begin
      r = $urandom_range(0, 99);
      gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (kbd.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int n;
    logic [6:0] k;
    logic [6:0] mod_code;
    kbd = new();
    requests = 0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    long_hold = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_QUERY;
    in_scan_byte <= '0;
    in_query_key <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: query and pop extremes, every modifier, caps held, odd codes
    send(ACT_QUERY, 8'h00, 8'h00);
    send(ACT_POP, 8'hFF, 8'hFF);
    send(ACT_SCAN, 8'h1E, 8'h1E);
    send(ACT_SCAN, 8'h9E, 8'h1E);
    send(ACT_SCAN, {1'b0, SC_LSHIFT}, {1'b0, SC_LSHIFT});
    send(ACT_SCAN, 8'h02, 8'h80);
    send(ACT_SCAN, {1'b1, SC_LSHIFT}, {1'b0, SC_LSHIFT});
    send(ACT_SCAN, {1'b0, SC_RSHIFT}, {1'b0, SC_RSHIFT});
    send(ACT_SCAN, 8'h10, 8'h00);
    send(ACT_SCAN, {1'b1, SC_RSHIFT}, {1'b0, SC_RSHIFT});
    send(ACT_SCAN, {1'b0, SC_CTRL}, {1'b0, SC_CTRL});
    send(ACT_SCAN, {1'b0, SC_ALT}, {1'b0, SC_ALT});
    send(ACT_SCAN, {1'b1, SC_CTRL}, 8'h00);
    send(ACT_SCAN, {1'b1, SC_ALT}, 8'h00);
    // caps held down: each repeated press toggles
    send(ACT_SCAN, {1'b0, SC_CAPS}, {1'b0, SC_CAPS});
    send(ACT_SCAN, {1'b0, SC_CAPS}, {1'b0, SC_CAPS});
    send(ACT_SCAN, {1'b0, SC_CAPS}, {1'b0, SC_CAPS});
    send(ACT_SCAN, 8'h1E, 8'hFF);
    send(ACT_SCAN, {1'b1, SC_CAPS}, {1'b0, SC_CAPS});
    // untranslated codes and a release, keypad keys
    send(ACT_SCAN, 8'h00, 8'h00);
    send(ACT_SCAN, 8'h7F, 8'h7F);
    send(ACT_SCAN, 8'hFF, 8'h7F);
    send(ACT_SCAN, 8'h4E, 8'h4A);
    send(ACT_SPARE, 8'h4A, 8'h4E);
    send(ACT_POP, 8'h00, 8'h7F);

    // fill the fifo past full without idling, then empty it and keep popping once it is empty
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    for (int i = 0; i < FIFO_DEPTH + 4; i++) begin
      send(ACT_SCAN, 8'($urandom_range(8'h10, 8'h19)), 8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < FIFO_DEPTH + 2; i++) begin
      send(ACT_POP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // long hold on the result side while requests keep coming
    long_hold = 1'b1;
    tx_gaps = 1'b0;
    for (int i = 0; i < 40; i++) begin
      send(ACT_SCAN, 8'($urandom_range(1, 8'h39)), 8'($urandom_range(0, 127)));
    end
    tx_gaps = 1'b1;
    // sender pauses until every status word is back
    in_valid <= 1'b0;
    wait_drained();

    // random typing sessions with pops, queries and some noise
    n = 0;
    while (n < 900) begin
      if (n >= 450 && n < 650) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else if (n >= 650) begin
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        // keystroke, sometimes auto-repeated, then its release
        k = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(8'h3B, 8'h7F))
                                         : 7'($urandom_range(1, 8'h39));
        send(ACT_SCAN, {1'b0, k}, {1'b0, k});
        n++;
        if ($urandom_range(0, 5) == 0) begin
          send(ACT_SCAN, {1'b0, k}, 8'($urandom_range(0, 255)));
          n++;
        end
        send(ACT_SCAN, {1'b1, k}, {1'b0, k});
        n++;
      end else if (r < 57) begin
        // modifier press or release
        case ($urandom_range(0, 4))
          0: mod_code = SC_LSHIFT;
          1: mod_code = SC_RSHIFT;
          2: mod_code = SC_CTRL;
          3: mod_code = SC_ALT;
          default: mod_code = SC_CAPS;
        endcase
        send(ACT_SCAN, {1'($urandom_range(0, 1)), mod_code}, {1'b0, mod_code});
        n++;
      end else if (r < 80) begin
        repeat ($urandom_range(1, 8)) begin
          send(ACT_POP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 127)));
          n++;
        end
      end else if (r < 88) begin
        send(ACT_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        n++;
      end else begin
        send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        n++;
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    $display("run covered %0d requests and %0d status words: %0d characters popped,",
             requests, kbd.checked, kbd.chars_popped);
    $display("%0d dropped on a full fifo, modifiers, caps toggling and a long output hold",
             kbd.chars_dropped);
    if (kbd.errors == 0 && kbd.pending() == 0) begin
      $display("[scancode_to_ascii_keyboard_fifo] OK");
    end else begin
      $display("[scancode_to_ascii_keyboard_fifo] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/scta_pkg.sv
rtl/core/scta_ram.sv
rtl/core/scta_keymap.sv
rtl/core/scancode_to_ascii_keyboard_fifo.sv
rtl/core/scta_checker.sv
bench/tb_scancode_to_ascii_keyboard_fifo.sv
